// File: src/fdp_pkg.sv
package fdp_pkg;

  localparam int unsigned LEN_W  = 8;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned CNT_W  = 32;

  localparam logic [7:0] PAD_CHAR   = 8'h3F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_GOOD,
    KIND_RAW,
    KIND_EMPTY,
    KIND_SKIP
  } desc_kind_t;

  typedef struct packed {
    desc_kind_t        kind;
    logic              bank;
    logic [LEN_W-1:0]  plen;
    logic [CHAN_W-1:0] chan;
  } desc_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ADDR,
    B_DATA,
    B_FINISH,
    B_OUT
  } back_state_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      r = {1'b1, 4'(c - CHAR_ZERO)};
    end else if (c inside {[CHAR_UP_A:CHAR_UP_F]}) begin
      r = {1'b1, 4'(c - CHAR_UP_A + HEX_TEN)};
    end else if (c inside {[CHAR_LO_A:CHAR_LO_F]}) begin
      r = {1'b1, 4'(c - CHAR_LO_A + HEX_TEN)};
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// File: src/fdp_frame_ram.sv
module fdp_frame_ram #(
  parameter int unsigned AW = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/fdp_desc_fifo.sv
module fdp_desc_fifo import fdp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output desc_t head
);

  desc_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/fdp_front.sv
module fdp_front import fdp_pkg::*; #(
  parameter int unsigned MAX_FRAME    = 64,
  parameter int unsigned NUM_CHANNELS = 6,
  parameter int unsigned CW           = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  output logic          char_stall,
  input  logic [7:0]    data_byte,
  input  logic          frame_end,
  input  logic          queue_full,
  output logic          push,
  output desc_t         push_desc,
  output logic          wr_en,
  output logic [CW:0]   wr_addr,
  output logic [7:0]    wr_data
);

  localparam logic [7:0] CHAN_LO = CHAR_ZERO + 8'd1;
  localparam logic [7:0] CHAN_HI = CHAR_ZERO + 8'(NUM_CHANNELS - 1);

  logic [CW-1:0] write_index;
  logic          overflow_flag;
  logic          bank;
  logic [7:0]    chan_char;

  logic          accept;
  logic [CW+3:0] plen_ext;
  logic [CW-1:0] plen;
  logic [4:0]    hex;
  logic          good;

  assign char_stall = queue_full;
  assign accept     = char_valid && !queue_full;

  assign wr_en   = accept && !frame_end && (write_index < CW'(MAX_FRAME - 1));
  assign wr_addr = {bank, write_index};
  assign wr_data = data_byte;

  assign plen_ext = (CW + 4)'(write_index) - (CW + 4)'(1);
  assign plen     = plen_ext[CW-1:0];
  assign hex      = hex_decode(data_byte);
  assign good     = hex[4] && (hex[3:0] == plen_ext[3:0]) &&
                    (chan_char inside {[CHAN_LO:CHAN_HI]});

  assign push = accept && frame_end;

  always_comb begin
    push_desc.bank = bank;
    push_desc.plen = LEN_W'(plen);
    push_desc.chan = CHAN_W'(chan_char - CHAR_ZERO);
    if (overflow_flag || write_index == '0) begin
      push_desc.kind = KIND_EMPTY;
    end else if (good) begin
      push_desc.kind = (plen == '0) ? KIND_SKIP : KIND_GOOD;
    end else begin
      push_desc.kind = (plen == '0) ? KIND_EMPTY : KIND_RAW;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && write_index == '0) begin
      chan_char <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index   <= '0;
      overflow_flag <= 1'b0;
      bank          <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        write_index   <= '0;
        overflow_flag <= 1'b0;
        bank          <= ~bank;
      end else if (wr_en) begin
        write_index <= write_index + CW'(1);
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

endmodule

// File: src/fdp_back.sv
module fdp_back import fdp_pkg::*; #(
  parameter int unsigned PACKET_LEN   = 7,
  parameter int unsigned NUM_CHANNELS = 6,
  parameter int unsigned CW           = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  input  desc_t             desc,
  output logic              pop,
  output logic              rd_en,
  output logic [CW:0]       rd_addr,
  input  logic [7:0]        rd_data,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [2:0]        out_channel,
  output logic [55:0]       packet_bytes,
  output logic [2:0]        byte_count,
  output logic [5:0]        check_digit,
  output logic              is_rejected,
  output logic              last,
  output logic [CNT_W-1:0]  frames_total,
  output logic [CNT_W-1:0]  frames_rejected,
  output logic [CNT_W-1:0]  channel_bytes
);

  localparam int unsigned JW    = (PACKET_LEN > 1) ? $clog2(PACKET_LEN) : 1;
  localparam int unsigned NW    = $clog2(PACKET_LEN + 1);
  localparam int unsigned NCW   = $clog2(NUM_CHANNELS);
  localparam int unsigned ACC_W = PACKET_LEN * 8;

  back_state_t state, state_next;

  desc_kind_t       kind;
  logic             bank;
  logic [CW-1:0]    plen;
  logic [NCW-1:0]   chan;
  logic [CW-1:0]    pos;
  logic [JW-1:0]    lane;
  logic [ACC_W-1:0] acc;
  logic [NW-1:0]    real_count;
  logic [NW-1:0]    count;
  logic             final_pkt;

  logic [CNT_W-1:0] total_count;
  logic [CNT_W-1:0] reject_count;
  logic [CNT_W-1:0] byte_counters [NUM_CHANNELS];

  logic             start;
  logic             take;
  logic             load_out;
  logic             done_out;
  logic             payload_end;

  logic [CW-1:0]    pos_inc;
  logic [ACC_W+55:0] acc_ext;
  logic [NW+2:0]    count_ext;
  logic [NCW+2:0]   chan_ext;
  logic [7:0]       digit;
  logic [CNT_W-1:0] amount;
  logic [CNT_W-1:0] chan_sum;
  logic [ACC_W-1:0] acc_init;

  assign pos_inc     = pos + CW'(1);
  assign payload_end = (pos_inc == plen) || (lane == JW'(PACKET_LEN - 1));
  assign rd_addr     = {bank, pos_inc};
  assign acc_ext     = {56'd0, acc};
  assign count_ext   = {3'd0, count};
  assign chan_ext    = {3'd0, chan};
  assign digit       = CHAR_ZERO + 8'(real_count);
  assign amount      = (kind == KIND_GOOD) ? CNT_W'(PACKET_LEN + 1) : CNT_W'(count);
  assign chan_sum    = sat_add(byte_counters[chan], amount);
  assign acc_init    = (kind == KIND_GOOD) ? {PACKET_LEN{PAD_CHAR}} : '0;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (desc_valid) begin
          case (desc.kind)
            KIND_SKIP:  state_next = B_IDLE;
            KIND_EMPTY: state_next = B_FINISH;
            default:    state_next = B_ADDR;
          endcase
        end
      end
      B_ADDR:   state_next = B_DATA;
      B_DATA:   state_next = payload_end ? B_FINISH : B_ADDR;
      B_FINISH: state_next = B_OUT;
      B_OUT: begin
        if (!result_stall) begin
          state_next = final_pkt ? B_IDLE : B_ADDR;
        end
      end
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    start    = 1'b0;
    take     = 1'b0;
    load_out = 1'b0;
    done_out = 1'b0;
    rd_en    = 1'b0;
    pop      = 1'b0;
    case (state)
      B_IDLE: begin
        start = desc_valid;
        pop   = desc_valid && (desc.kind == KIND_SKIP);
      end
      B_ADDR:   rd_en = 1'b1;
      B_DATA:   take = 1'b1;
      B_FINISH: begin
        load_out = 1'b1;
        pop      = final_pkt;
      end
      B_OUT:    done_out = !result_stall;
      default:  start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind       <= desc.kind;
      bank       <= desc.bank;
      plen       <= desc.plen[CW-1:0];
      chan       <= (desc.kind == KIND_GOOD) ? desc.chan[NCW-1:0] : '0;
      pos        <= '0;
      lane       <= '0;
      acc        <= (desc.kind == KIND_GOOD) ? {PACKET_LEN{PAD_CHAR}} : '0;
      real_count <= '0;
      count      <= '0;
      final_pkt  <= (desc.kind == KIND_EMPTY);
    end else if (take) begin
      acc[lane*8 +: 8] <= rd_data;
      real_count       <= real_count + NW'(rd_data != PAD_CHAR);
      count            <= count + NW'(1);
      pos              <= pos_inc;
      lane             <= lane + JW'(1);
      final_pkt        <= (pos_inc == plen);
    end else if (done_out && !final_pkt) begin
      lane       <= '0;
      acc        <= acc_init;
      real_count <= '0;
      count      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_channel     <= chan_ext[2:0];
      packet_bytes    <= acc_ext[55:0];
      channel_bytes   <= chan_sum;
      frames_total    <= total_count;
      frames_rejected <= reject_count;
      last            <= final_pkt;
      if (kind == KIND_GOOD) begin
        byte_count  <= 3'(PACKET_LEN);
        check_digit <= digit[5:0];
        is_rejected <= 1'b0;
      end else begin
        byte_count  <= count_ext[2:0];
        check_digit <= '0;
        is_rejected <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      total_count  <= '0;
      reject_count <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        byte_counters[i] <= '0;
      end
    end else begin
      if (start) begin
        total_count <= sat_add(total_count, CNT_W'(1));
        if (desc.kind == KIND_RAW || desc.kind == KIND_EMPTY) begin
          reject_count <= sat_add(reject_count, CNT_W'(1));
        end
      end
      if (load_out) begin
        byte_counters[chan] <= chan_sum;
        result_valid        <= 1'b1;
      end else if (done_out) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/frame_demux_packetizer_unit.sv
// Channel   Handshake                  Payload
// char      char_valid / char_stall    data_byte, frame_end
// result    result_valid / result_stall out_channel, packet_bytes, byte_count,
//                                       check_digit, is_rejected, last,
//                                       frames_total, frames_rejected, channel_bytes
//
// Characters are taken one per cycle while char_stall is low and written into one of two frame banks.
// A frame end queues a descriptor; the packetizer takes it and reads the bank
// back byte by byte, each byte through an address state and a data state, then
// loads the result register in a finish state; it holds until the result transfer.
// The character side stalls only while both banks hold frames not yet read out.
// Reset is synchronous and clears the counters, the queue and the valid flags.
module frame_demux_packetizer_unit import fdp_pkg::*; #(
  parameter int unsigned MAX_FRAME    = 64,
  parameter int unsigned PACKET_LEN   = 7,
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  logic [7:0]       data_byte,
  input  logic             frame_end,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [2:0]       out_channel,
  output logic [55:0]      packet_bytes,
  output logic [2:0]       byte_count,
  output logic [5:0]       check_digit,
  output logic             is_rejected,
  output logic             last,
  output logic [CNT_W-1:0] frames_total,
  output logic [CNT_W-1:0] frames_rejected,
  output logic [CNT_W-1:0] channel_bytes
);

  localparam int unsigned CW = $clog2(MAX_FRAME);

  logic        queue_full;
  logic        queue_valid;
  logic        push;
  logic        pop;
  desc_t       push_desc;
  desc_t       head;
  logic        wr_en;
  logic [CW:0] wr_addr;
  logic [7:0]  wr_data;
  logic        rd_en;
  logic [CW:0] rd_addr;
  logic [7:0]  rd_data;

  fdp_front #(
    .MAX_FRAME    (MAX_FRAME),
    .NUM_CHANNELS (NUM_CHANNELS),
    .CW           (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .queue_full (queue_full),
    .push       (push),
    .push_desc  (push_desc),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  fdp_frame_ram #(
    .AW (CW + 1)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fdp_desc_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .head      (head)
  );

  fdp_back #(
    .PACKET_LEN   (PACKET_LEN),
    .NUM_CHANNELS (NUM_CHANNELS),
    .CW           (CW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .desc_valid      (queue_valid),
    .desc            (head),
    .pop             (pop),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_channel     (out_channel),
    .packet_bytes    (packet_bytes),
    .byte_count      (byte_count),
    .check_digit     (check_digit),
    .is_rejected     (is_rejected),
    .last            (last),
    .frames_total    (frames_total),
    .frames_rejected (frames_rejected),
    .channel_bytes   (channel_bytes)
  );

endmodule
